@@ design/crhs_pkg.sv @@
`timescale 1ns / 1ps
package crhs_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned FracW = 40;
  localparam int unsigned TolW  = 21;
  localparam int unsigned CapW  = 8;
  localparam int unsigned NumCoef = 3;

  localparam logic [TolW-1:0] TolReset = TolW'(1);
  localparam logic [CapW-1:0] CapReset = CapW'(100);

  typedef logic signed [DataW-1:0] q_t;
  typedef logic [DataW-1:0]        u64_t;
  typedef logic [2*DataW-1:0]      u128_t;

  localparam q_t OneQ = q_t'(64'sh0000_0100_0000_0000);

  typedef enum logic [1:0] {
    STAT_CONVERGED      = 2'd0,
    STAT_NOT_BRACKETED  = 2'd1,
    STAT_CAP_REACHED    = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_TOLERANCE = 1'b0,
    REG_ITER_CAP  = 1'b1
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_P,
    OP_HORNER,
    OP_STORE_FA,
    OP_STORE_FB,
    OP_STORE_FD,
    OP_SWAP,
    OP_DM,
    OP_DS_DM,
    OP_MUL_SEC,
    OP_DIV,
    OP_DS_Q,
    OP_STEP,
    OP_NEXT_D,
    OP_B_FROM_D,
    OP_ADVANCE,
    OP_FINISH
  } dp_op_e;

  typedef enum logic [1:0] {
    TGT_A,
    TGT_B,
    TGT_D
  } eval_tgt_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EV_MUL,
    S_EV_WAIT,
    S_EV_DONE,
    S_CHECK,
    S_LOOP,
    S_TEST,
    S_DSDM,
    S_SEC_MUL,
    S_SEC_WAIT,
    S_DIV_WAIT,
    S_STEP,
    S_NEXT,
    S_UPDATE,
    S_FIN
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e  op;
    status_e fin;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic horner_last;
    logic same_ab;
    logic bc_small;
    logic den_small;
    logic fd_small;
    logic cap_hit;
  } dp_stat_t;

endpackage

@@ design/crhs_if.sv @@
`timescale 1ns / 1ps
interface crhs_item_if;
  import crhs_pkg::*;
  logic valid;
  logic ready;
  q_t   bracket_low;
  q_t   bracket_high;
  q_t   coef_square;
  q_t   coef_linear;
  q_t   coef_constant;

  modport source (output valid, bracket_low, bracket_high, coef_square, coef_linear,
                  coef_constant, input ready);
  modport sink   (input valid, bracket_low, bracket_high, coef_square, coef_linear,
                  coef_constant, output ready);
endinterface

interface crhs_result_if;
  import crhs_pkg::*;
  logic           valid;
  logic           ready;
  q_t             root;
  logic [1:0]     status;
  logic [CapW-1:0] iterations_used;

  modport source (output valid, root, status, iterations_used, input ready);
  modport sink   (input valid, root, status, iterations_used, output ready);
endinterface

@@ design/crhs_mul.sv @@
`timescale 1ns / 1ps
module crhs_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  crhs_pkg::u64_t a_i,
  input  crhs_pkg::u64_t b_i,
  output crhs_pkg::u128_t prod_o,
  output logic           done_o
);
  import crhs_pkg::*;

  u64_t        a_q, b_q;
  logic [63:0] pp_q, pp_d;
  logic [1:0]  sh_q;
  u128_t       acc_q, pp_shift;
  logic [2:0]  cnt_q;
  logic        busy_q, done_q;
  logic [31:0] ah, bh;

  always_comb begin
    ah   = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    bh   = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp_d = {32'b0, ah} * {32'b0, bh};
  end

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_shift = {64'b0, pp_q};
      2'd1:    pp_shift = {32'b0, pp_q, 32'b0};
      2'd2:    pp_shift = {pp_q, 64'b0};
      default: pp_shift = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd4);
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= pp_d;
        sh_q <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_shift;
      end
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

@@ design/crhs_div.sv @@
`timescale 1ns / 1ps
module crhs_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  crhs_pkg::u64_t hi_i,
  input  crhs_pkg::u64_t lo_i,
  input  crhs_pkg::u64_t den_i,
  output crhs_pkg::u64_t quot_o,
  output logic           ovf_o,
  output logic           done_o
);
  import crhs_pkg::*;

  u64_t        r_q, lo_q, q_q, d_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q, ovf_q;
  logic [64:0] rr, rs;
  logic        sub;

  always_comb begin
    rr  = {r_q, lo_q[63]};
    rs  = rr - {1'b0, d_q};
    sub = rr >= {1'b0, d_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= (start_i && (hi_i >= den_i)) || (busy_q && (cnt_q == 6'd63));
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= hi_i < den_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= hi_i;
      lo_q  <= lo_i;
      d_q   <= den_i;
      q_q   <= '0;
      ovf_q <= hi_i >= den_i;
    end else if (busy_q) begin
      r_q  <= sub ? rs[63:0] : rr[63:0];
      lo_q <= {lo_q[62:0], 1'b0};
      q_q  <= {q_q[62:0], sub};
    end
  end

  assign quot_o = q_q;
  assign ovf_o  = ovf_q;
  assign done_o = done_q;

endmodule

@@ design/crhs_dp.sv @@
`timescale 1ns / 1ps
module crhs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  crhs_pkg::dp_cmd_t          cmd_i,
  input  crhs_pkg::q_t               bracket_low_i,
  input  crhs_pkg::q_t               bracket_high_i,
  input  crhs_pkg::q_t               coef_square_i,
  input  crhs_pkg::q_t               coef_linear_i,
  input  crhs_pkg::q_t               coef_constant_i,
  input  logic [crhs_pkg::TolW-1:0]  tol_i,
  input  logic [crhs_pkg::CapW-1:0]  cap_i,
  output crhs_pkg::dp_stat_t         stat_o,
  output crhs_pkg::q_t               root_o,
  output logic [1:0]                 status_o,
  output logic [crhs_pkg::CapW-1:0]  iters_o
);
  import crhs_pkg::*;

  localparam q_t MaxQ = {1'b0, {(DataW-1){1'b1}}};
  localparam q_t MinQ = {1'b1, {(DataW-1){1'b0}}};

  function automatic u64_t mag(q_t v);
    return v[DataW-1] ? u64_t'(-v) : u64_t'(v);
  endfunction

  function automatic u64_t absdiff(q_t x, q_t y);
    logic signed [DataW:0] df;
    logic signed [DataW:0] nd;
    df = {x[DataW-1], x} - {y[DataW-1], y};
    nd = -df;
    return df[DataW] ? nd[DataW-1:0] : df[DataW-1:0];
  endfunction

  function automatic q_t sadd(q_t x, q_t y);
    logic signed [DataW:0] s;
    s = {x[DataW-1], x} + {y[DataW-1], y};
    if (s[DataW] != s[DataW-1]) return s[DataW] ? MinQ : MaxQ;
    return s[DataW-1:0];
  endfunction

  function automatic q_t from_signmag(logic neg, u64_t m, logic ovf);
    if (!neg) return (ovf || m[DataW-1]) ? MaxQ : q_t'(m);
    if (ovf || m[DataW-1]) return MinQ;
    return -q_t'(m);
  endfunction

  function automatic logic same_sign(q_t x, q_t y);
    return (!x[DataW-1] && (x != '0) && !y[DataW-1] && (y != '0)) ||
           (x[DataW-1] && y[DataW-1]);
  endfunction

  q_t         a_q, b_q, c_q, fa_q, fb_q, fc_q, fd_q, d_q;
  q_t         dm_q, ds_q, dd_q, ex_q, p_q;
  q_t         coef_q [NumCoef];
  logic [1:0] k_q;
  logic [CapW-1:0] iter_q;
  logic       pneg_q, sneg_q;
  q_t         root_q;
  status_e    status_q;
  logic [CapW-1:0] iters_q;

  u64_t       tol64, mdf, mul_a, mul_b, quot;
  u128_t      prod;
  logic       mul_start, mul_done, div_start, div_done, div_ovf;
  q_t         horner_d, ds_q_d, dd_sel, dd_d, dm_d;
  logic signed [DataW:0] cb;
  logic [TolW:0]  tol_p1;
  q_t         step;

  assign tol64 = {{(DataW-TolW){1'b0}}, tol_i};
  assign mdf   = absdiff(fa_q, fb_q);

  always_comb begin
    mul_start = (cmd_i.op == OP_MUL_P) || (cmd_i.op == OP_MUL_SEC);
    mul_a     = (cmd_i.op == OP_MUL_SEC) ? mag(fb_q) : mag(p_q);
    mul_b     = (cmd_i.op == OP_MUL_SEC) ? absdiff(a_q, b_q) : mag(ex_q);
    div_start = cmd_i.op == OP_DIV;
  end

  crhs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  crhs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (prod[2*DataW-1:DataW]),
    .lo_i    (prod[DataW-1:0]),
    .den_i   (mdf),
    .quot_o  (quot),
    .ovf_o   (div_ovf),
    .done_o  (div_done)
  );

  always_comb begin
    horner_d = sadd(from_signmag(pneg_q, prod[DataW+FracW-1:FracW],
                                 |prod[2*DataW-1:DataW+FracW]), coef_q[k_q]);
    ds_q_d   = from_signmag(sneg_q, quot, div_ovf);
    cb       = {c_q[DataW-1], c_q} - {b_q[DataW-1], b_q};
    dm_d     = q_t'(cb >>> 1);
    if ((ds_q > 0 && dm_q < 0) || (ds_q < 0 && dm_q > 0) || (mag(ds_q) > mag(dm_q))) begin
      dd_sel = dm_q;
    end else begin
      dd_sel = ds_q;
    end
    tol_p1 = {1'b0, tol_i} + {{TolW{1'b0}}, 1'b1};
    step   = q_t'({{(DataW-TolW){1'b0}}, tol_p1[TolW:1]});
    if (mag(dd_sel) < tol64) begin
      if (dm_q > 0) dd_d = step;
      else if (dm_q < 0) dd_d = -step;
      else dd_d = '0;
    end else begin
      dd_d = dd_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      iter_q <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_LOAD: begin
          k_q    <= '0;
          iter_q <= '0;
        end
        OP_HORNER: k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
        OP_ADVANCE: iter_q <= iter_q + CapW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        a_q       <= bracket_low_i;
        b_q       <= bracket_high_i;
        c_q       <= bracket_low_i;
        coef_q[0] <= coef_square_i;
        coef_q[1] <= coef_linear_i;
        coef_q[2] <= coef_constant_i;
        ex_q      <= bracket_low_i;
        p_q       <= OneQ;
      end
      OP_MUL_P: pneg_q <= p_q[DataW-1] ^ ex_q[DataW-1];
      OP_HORNER: p_q <= horner_d;
      OP_STORE_FA: begin
        fa_q <= p_q;
        fc_q <= p_q;
        ex_q <= b_q;
        p_q  <= OneQ;
      end
      OP_STORE_FB: fb_q <= p_q;
      OP_STORE_FD: fd_q <= p_q;
      OP_SWAP: begin
        if (mag(fc_q) < mag(fb_q)) begin
          b_q  <= c_q;
          c_q  <= b_q;
          a_q  <= b_q;
          fb_q <= fc_q;
          fc_q <= fb_q;
          fa_q <= fb_q;
        end
      end
      OP_DM: dm_q <= dm_d;
      OP_DS_DM: ds_q <= dm_q;
      OP_DIV: sneg_q <= ((fb_q < 0) ^ (a_q < b_q) ^ (fa_q < fb_q)) == 1'b0;
      OP_DS_Q: ds_q <= ds_q_d;
      OP_STEP: dd_q <= dd_d;
      OP_NEXT_D: begin
        d_q  <= sadd(b_q, dd_q);
        ex_q <= sadd(b_q, dd_q);
        p_q  <= OneQ;
      end
      OP_B_FROM_D: b_q <= d_q;
      OP_ADVANCE: begin
        a_q  <= b_q;
        b_q  <= d_q;
        fa_q <= fb_q;
        fb_q <= fd_q;
        if (same_sign(fd_q, fc_q)) begin
          c_q  <= b_q;
          fc_q <= fb_q;
        end
      end
      OP_FINISH: begin
        status_q <= cmd_i.fin;
        iters_q  <= (cmd_i.fin == STAT_NOT_BRACKETED) ? '0 : iter_q;
        root_q   <= (cmd_i.fin == STAT_NOT_BRACKETED) ? '0 : b_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    stat_o.mul_done    = mul_done;
    stat_o.div_done    = div_done;
    stat_o.horner_last = k_q == 2'd2;
    stat_o.same_ab     = same_sign(fa_q, fb_q);
    stat_o.bc_small    = absdiff(b_q, c_q) < tol64;
    stat_o.den_small   = (mdf < tol64) || (mdf == '0);
    stat_o.fd_small    = mag(fd_q) < tol64;
    stat_o.cap_hit     = iter_q >= cap_i;
  end

  assign root_o   = root_q;
  assign status_o = status_q;
  assign iters_o  = iters_q;

endmodule

@@ design/crhs_ctrl.sv @@
`timescale 1ns / 1ps
module crhs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  crhs_pkg::dp_stat_t stat_i,
  output crhs_pkg::dp_cmd_t  cmd_o
);
  import crhs_pkg::*;

  ctrl_state_e state_q, state_d;
  eval_tgt_e   tgt_q, tgt_d;
  status_e     fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  logic        fin_go;

  assign fin_go = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    tgt_d   = tgt_q;
    fin_d   = fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tgt_d   = TGT_A;
          state_d = S_EV_MUL;
        end
      end
      S_EV_MUL: state_d = S_EV_WAIT;
      S_EV_WAIT: begin
        if (stat_i.mul_done) state_d = stat_i.horner_last ? S_EV_DONE : S_EV_MUL;
      end
      S_EV_DONE: begin
        unique case (tgt_q)
          TGT_A: begin
            tgt_d   = TGT_B;
            state_d = S_EV_MUL;
          end
          TGT_B: state_d = S_CHECK;
          default: state_d = S_UPDATE;
        endcase
      end
      S_CHECK: begin
        if (stat_i.same_ab) begin
          fin_d   = STAT_NOT_BRACKETED;
          state_d = S_FIN;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_LOOP: begin
        if (stat_i.cap_hit) begin
          fin_d   = STAT_CAP_REACHED;
          state_d = S_FIN;
        end else begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (stat_i.bc_small) begin
          fin_d   = STAT_CONVERGED;
          state_d = S_FIN;
        end else begin
          state_d = stat_i.den_small ? S_DSDM : S_SEC_MUL;
        end
      end
      S_DSDM: state_d = S_STEP;
      S_SEC_MUL: state_d = S_SEC_WAIT;
      S_SEC_WAIT: if (stat_i.mul_done) state_d = S_DIV_WAIT;
      S_DIV_WAIT: if (stat_i.div_done) state_d = S_STEP;
      S_STEP: state_d = S_NEXT;
      S_NEXT: begin
        tgt_d   = TGT_D;
        state_d = S_EV_MUL;
      end
      S_UPDATE: begin
        if (stat_i.fd_small) begin
          fin_d   = STAT_CONVERGED;
          state_d = S_FIN;
        end else begin
          state_d = S_LOOP;
        end
      end
      S_FIN: if (fin_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op    = OP_NONE;
    cmd_o.fin   = fin_q;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_EV_MUL: cmd_o.op = OP_MUL_P;
      S_EV_WAIT: if (stat_i.mul_done) cmd_o.op = OP_HORNER;
      S_EV_DONE: begin
        unique case (tgt_q)
          TGT_A: cmd_o.op = OP_STORE_FA;
          TGT_B: cmd_o.op = OP_STORE_FB;
          default: cmd_o.op = OP_STORE_FD;
        endcase
      end
      S_LOOP: if (!stat_i.cap_hit) cmd_o.op = OP_SWAP;
      S_TEST: if (!stat_i.bc_small) cmd_o.op = OP_DM;
      S_DSDM: cmd_o.op = OP_DS_DM;
      S_SEC_MUL: cmd_o.op = OP_MUL_SEC;
      S_SEC_WAIT: if (stat_i.mul_done) cmd_o.op = OP_DIV;
      S_DIV_WAIT: if (stat_i.div_done) cmd_o.op = OP_DS_Q;
      S_STEP: cmd_o.op = OP_STEP;
      S_NEXT: cmd_o.op = OP_NEXT_D;
      S_UPDATE: cmd_o.op = stat_i.fd_small ? OP_B_FROM_D : OP_ADVANCE;
      S_FIN: begin
        if (fin_go) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= TGT_A;
      fin_q       <= STAT_CONVERGED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tgt_q       <= tgt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/cubic_root_hybrid_secant_unit.sv @@
`timescale 1ns / 1ps
// Hybrid bisection/secant root finder for a monic cubic in signed Q23.40.
// item_i carries a bracket and three coefficients; result_o returns the root,
// a status (converged, not bracketed, cap reached) and the iteration count.
// Both channels use valid/ready; a beat moves when both are high.
// The APB port holds tolerance (address 0) and iteration cap (address 4).
// One item is worked at a time. Each cubic evaluation is three multiply-adds
// on the shared 32x32 multiplier, plus store. Each iteration takes a bisection
// step or a secant step; only the secant step uses the radix-2 divider.
// The result sits in an output register; the next item is taken as soon as
// that register has been loaded, even while the receiver stalls. A finished
// item waits for the output register to drain before it is written.
// Reset returns the controller to idle, drops result valid and sets the
// tolerance to 1 LSB and the iteration cap to 100.
module cubic_root_hybrid_secant_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  crhs_item_if.sink    item_i,
  crhs_result_if.source result_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import crhs_pkg::*;

  logic [TolW-1:0] tol_q;
  logic [CapW-1:0] cap_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;
  dp_cmd_t         cmd;
  dp_stat_t        stat;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
      cap_q <= CapReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TOLERANCE: tol_q <= pwdata[TolW-1:0];
        REG_ITER_CAP:  cap_q <= pwdata[CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TOLERANCE: prdata = {{(32-TolW){1'b0}}, tol_q};
      REG_ITER_CAP:  prdata = {{(32-CapW){1'b0}}, cap_q};
      default:       prdata = '0;
    endcase
  end

  crhs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  crhs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .bracket_low_i   (item_i.bracket_low),
    .bracket_high_i  (item_i.bracket_high),
    .coef_square_i   (item_i.coef_square),
    .coef_linear_i   (item_i.coef_linear),
    .coef_constant_i (item_i.coef_constant),
    .tol_i           (tol_q),
    .cap_i           (cap_q),
    .stat_o          (stat),
    .root_o          (result_o.root),
    .status_o        (result_o.status),
    .iters_o         (result_o.iterations_used)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_i.ready |=> !item_i.ready)
    else $error("item taken while previous item still in work");

  a_nb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status == STAT_NOT_BRACKETED) |->
    (result_o.root == '0) && (result_o.iterations_used == '0))
    else $error("not-bracketed result carries a root or iterations");

  a_tol_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr && (cfg_idx == REG_TOLERANCE) |=> tol_q == $past(pwdata[TolW-1:0]))
    else $error("tolerance write lost");

endmodule
